// ===== hw/rtl/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types, constants and decode functions for the MIDI stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

  localparam int CHANNEL_COUNT = 16;
  localparam int CH_W          = 4;

  // Status byte boundaries.
  localparam logic [7:0] REALTIME_FIRST = 8'hF8;
  localparam logic [7:0] SYSTEM_FIRST   = 8'hF0;
  localparam logic [7:0] SYSEX_START    = 8'hF0;
  localparam logic [7:0] SYSEX_END      = 8'hF7;
  localparam logic [7:0] MTC_QUARTER    = 8'hF1;
  localparam logic [7:0] SONG_POSITION  = 8'hF2;
  localparam logic [7:0] SONG_SELECT    = 8'hF3;

  // Channel message types (upper nibble).
  localparam logic [3:0] MSG_NOTE_OFF   = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON    = 4'h9;
  localparam logic [3:0] MSG_CONTROL    = 4'hB;
  localparam logic [3:0] MSG_PROGRAM    = 4'hC;
  localparam logic [3:0] MSG_PRESSURE   = 4'hD;
  localparam logic [3:0] MSG_PITCH_BEND = 4'hE;

  // Controller numbers.
  localparam logic [6:0] CC_BANK_HI    = 7'd0;
  localparam logic [6:0] CC_VOLUME     = 7'd7;
  localparam logic [6:0] CC_PAN        = 7'd10;
  localparam logic [6:0] CC_EXPRESSION = 7'd11;
  localparam logic [6:0] CC_BANK_LO    = 7'd32;
  localparam logic [6:0] CC_SUSTAIN    = 7'd64;
  localparam logic [6:0] CC_RESET_ALL  = 7'd121;

  localparam logic [13:0] BEND_CENTER = 14'd8192;
  localparam logic [6:0]  LEVEL_MAX   = 7'd127;
  localparam logic [6:0]  PAN_CENTER  = 7'd64;

  typedef struct packed {
    logic [13:0] bend;
    logic [6:0]  prog_num;
    logic [6:0]  bank_hi;
    logic [6:0]  bank_lo;
    logic [6:0]  volume;
    logic [6:0]  expression;
    logic [6:0]  pan;
    logic        sustain;
    logic [6:0]  pressure;
  } chan_t;

  localparam chan_t CHAN_DEFAULT = '{
    bend:       BEND_CENTER,
    prog_num:   7'd0,
    bank_hi:    7'd0,
    bank_lo:    7'd0,
    volume:     LEVEL_MAX,
    expression: LEVEL_MAX,
    pan:        PAN_CENTER,
    sustain:    1'b0,
    pressure:   7'd0
  };

  // Number of data bytes a channel status takes; zero for anything else.
  function automatic logic [1:0] need_for(input logic [7:0] st);
    logic [1:0] n;
    begin
      if (!st[7] || st >= SYSTEM_FIRST) begin
        n = 2'd0;
      end else if (st[7:4] == MSG_PROGRAM || st[7:4] == MSG_PRESSURE) begin
        n = 2'd1;
      end else begin
        n = 2'd2;
      end
      return n;
    end
  endfunction

  function automatic logic [1:0] sys_skip_for(input logic [7:0] st);
    logic [1:0] n;
    begin
      if (st == MTC_QUARTER || st == SONG_SELECT) begin
        n = 2'd1;
      end else if (st == SONG_POSITION) begin
        n = 2'd2;
      end else begin
        n = 2'd0;
      end
      return n;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/midi_stream_parser.sv =====
// ----------------------------------------------------------------------------
// midi_stream_parser
// Running-status MIDI parser with per-channel controller state.
// ----------------------------------------------------------------------------
// A completing byte passes through the input register and then the result
// register, which presents its result word on out_tvalid.
// Throughput: one byte per cycle unless a stalled out_tready holds the result;
// the channel state read-modify-write and the parser update both finish in
// the single stage between the two registers.
// Reset: rst_n (synchronous) and a soft-reset word both restore all channel
// defaults and clear the parser; rst_n also empties both registers.
`default_nettype none

module midi_stream_parser (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [39:0]  in_tdata,   // stream_byte[7:0], frame_stamp[39:8]
  input  wire logic [0:0]   in_tuser,   // mode[0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status_byte[7:0], first_data[14:8], second_data[21:15], time_tag[53:22],
  // bend_value[67:54], program_number[74:68], bank_number[88:75],
  // volume_level[95:89], expression_level[102:96], pan_position[109:103],
  // sustain_on[110], pressure_level[117:111], zero fill[119:118]
  output logic [119:0]      out_tdata
);

  // Input register.
  logic        in_valid_r;
  logic        in_mode_r;
  logic [7:0]  in_byte_r;
  logic [31:0] in_stamp_r;

  // Parser state.
  logic [7:0] running_r, running_nxt;
  logic [7:0] pending_r, pending_nxt;
  logic [6:0] hold0_r, hold0_nxt;
  logic [6:0] hold1_r, hold1_nxt;
  logic [1:0] count_r, count_nxt;
  logic [1:0] need_r, need_nxt;
  logic [1:0] skip_r, skip_nxt;
  logic       sysex_r, sysex_nxt;

  msp_pkg::chan_t chan_r [msp_pkg::CHANNEL_COUNT];

  logic out_valid_r;
  logic [119:0] out_data_r;

  logic advance;
  logic res_valid;
  logic [119:0] res_data;
  logic chan_we;
  logic [msp_pkg::CH_W-1:0] ch;
  msp_pkg::chan_t chan_rd, chan_wd;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    logic [7:0] pend;
    logic [1:0] need;
    logic [1:0] cnt;
    logic [7:0] st;
    logic [6:0] d1;
    logic [6:0] d2;
    logic       ch_ok;

    running_nxt = running_r;
    pending_nxt = pending_r;
    hold0_nxt   = hold0_r;
    hold1_nxt   = hold1_r;
    count_nxt   = count_r;
    need_nxt    = need_r;
    skip_nxt    = skip_r;
    sysex_nxt   = sysex_r;
    res_valid   = 1'b0;
    res_data    = '0;
    chan_we     = 1'b0;
    pend        = pending_r;
    need        = need_r;
    cnt         = count_r;
    st          = pending_r;
    d1          = 7'd0;
    d2          = 7'd0;
    ch          = pending_r[msp_pkg::CH_W-1:0];
    ch_ok       = 1'b0;
    chan_rd     = msp_pkg::CHAN_DEFAULT;
    chan_wd     = msp_pkg::CHAN_DEFAULT;

    if (in_byte_r >= msp_pkg::REALTIME_FIRST) begin
      // Real-time bytes leave everything untouched.
    end else if (in_byte_r[7]) begin
      pending_nxt = 8'd0;
      count_nxt   = 2'd0;
      skip_nxt    = 2'd0;
      if (in_byte_r >= msp_pkg::SYSTEM_FIRST) begin
        running_nxt = 8'd0;
        need_nxt    = 2'd0;
        sysex_nxt   = (in_byte_r == msp_pkg::SYSEX_START);
        skip_nxt    = msp_pkg::sys_skip_for(in_byte_r);
      end else begin
        sysex_nxt   = 1'b0;
        running_nxt = in_byte_r;
        pending_nxt = in_byte_r;
        need_nxt    = msp_pkg::need_for(in_byte_r);
      end
    end else if (sysex_r) begin
      // SysEx payload is dropped.
    end else if (skip_r != 2'd0) begin
      skip_nxt = skip_r - 2'd1;
    end else if (pending_r != 8'd0 || running_r != 8'd0) begin
      if (pending_r == 8'd0) begin
        pend = running_r;
        need = msp_pkg::need_for(running_r);
        cnt  = 2'd0;
      end
      pending_nxt = pend;
      need_nxt    = need;
      count_nxt   = cnt;
      if (need != 2'd0) begin
        if (cnt == 2'd0) begin
          hold0_nxt = in_byte_r[6:0];
        end else if (cnt == 2'd1) begin
          hold1_nxt = in_byte_r[6:0];
        end
        cnt       = cnt + 2'd1;
        count_nxt = cnt;
        if (cnt >= need) begin
          // Message complete: update the channel and emit it.
          st    = pend;
          ch    = pend[msp_pkg::CH_W-1:0];
          ch_ok = ({1'b0, ch} < (msp_pkg::CH_W + 1)'(msp_pkg::CHANNEL_COUNT));
          d1    = hold0_nxt;
          d2    = (need > 2'd1) ? hold1_nxt : 7'd0;
          if (st[7:4] == msp_pkg::MSG_NOTE_ON && d2 == 7'd0) begin
            st = {msp_pkg::MSG_NOTE_OFF, st[3:0]};
          end
          if (ch_ok) begin
            chan_rd = chan_r[ch];
          end
          chan_wd = chan_rd;
          case (st[7:4])
            msp_pkg::MSG_CONTROL: begin
              case (d1)
                msp_pkg::CC_BANK_HI:    chan_wd.bank_hi    = d2;
                msp_pkg::CC_BANK_LO:    chan_wd.bank_lo    = d2;
                msp_pkg::CC_VOLUME:     chan_wd.volume     = d2;
                msp_pkg::CC_PAN:        chan_wd.pan        = d2;
                msp_pkg::CC_EXPRESSION: chan_wd.expression = d2;
                msp_pkg::CC_SUSTAIN:    chan_wd.sustain    = d2[6];
                msp_pkg::CC_RESET_ALL: begin
                  chan_wd.bend       = msp_pkg::BEND_CENTER;
                  chan_wd.expression = msp_pkg::LEVEL_MAX;
                  chan_wd.pan        = msp_pkg::PAN_CENTER;
                  chan_wd.sustain    = 1'b0;
                  chan_wd.pressure   = 7'd0;
                end
                default: ;
              endcase
            end
            msp_pkg::MSG_PROGRAM:    chan_wd.prog_num = d1;
            msp_pkg::MSG_PRESSURE:   chan_wd.pressure = d1;
            msp_pkg::MSG_PITCH_BEND: chan_wd.bend     = {d2, d1};
            default: ;
          endcase
          chan_we   = ch_ok;
          res_valid = ch_ok;
          res_data  = {2'b00, chan_wd.pressure, chan_wd.sustain, chan_wd.pan,
                       chan_wd.expression, chan_wd.volume,
                       chan_wd.bank_hi, chan_wd.bank_lo, chan_wd.prog_num,
                       chan_wd.bend, in_stamp_r, d2, d1, st};

          pending_nxt = running_r;
          need_nxt    = msp_pkg::need_for(running_r);
          count_nxt   = 2'd0;
          hold0_nxt   = 7'd0;
          hold1_nxt   = 7'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      in_mode_r  <= in_tuser[0];
      in_byte_r  <= in_tdata[7:0];
      in_stamp_r <= in_tdata[39:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && in_mode_r)) begin
      running_r <= 8'd0;
      pending_r <= 8'd0;
      hold0_r   <= 7'd0;
      hold1_r   <= 7'd0;
      count_r   <= 2'd0;
      need_r    <= 2'd0;
      skip_r    <= 2'd0;
      sysex_r   <= 1'b0;
      for (int i = 0; i < msp_pkg::CHANNEL_COUNT; i++) begin
        chan_r[i] <= msp_pkg::CHAN_DEFAULT;
      end
    end else if (advance) begin
      running_r <= running_nxt;
      pending_r <= pending_nxt;
      hold0_r   <= hold0_nxt;
      hold1_r   <= hold1_nxt;
      count_r   <= count_nxt;
      need_r    <= need_nxt;
      skip_r    <= skip_nxt;
      sysex_r   <= sysex_nxt;
      if (chan_we) begin
        chan_r[ch] <= chan_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && !in_mode_r && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && !in_mode_r && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives midi_stream_parser with a short directed table and then a long
// random byte stream of well-formed and truncated channel messages mixed with real-time,
// SysEx, system-common, noise and soft-reset words. A local parser model
// predicts each result word, which is compared field by field on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Result word layout, highest field first.
  typedef struct packed {
    logic [1:0]  pad;
    logic [6:0]  pressure;
    logic        sustain;
    logic [6:0]  pan;
    logic [6:0]  expression;
    logic [6:0]  volume;
    logic [13:0] bank;
    logic [6:0]  prog;
    logic [13:0] bend;
    logic [31:0] time_tag;
    logic [6:0]  second;
    logic [6:0]  first;
    logic [7:0]  status;
  } midi_word_t;

  typedef struct {
    bit         mode;
    bit [7:0]   b;
    bit [31:0]  stamp;
    bit         fixed_valid;
    midi_word_t fixed;
  } feed_t;

  // Directed row: a typed expectation assumes all channel state at defaults.
  typedef struct packed {
    bit        mode;
    bit [7:0]  b;
    bit [31:0] stamp;
    bit        typed;
    bit [7:0]  t_st;
    bit [6:0]  t_d1;
    bit [6:0]  t_d2;
  } row_t;

  localparam int DIRECTED_ROWS = 27;
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b1, 8'hA5, 32'h0000_0000, 1'b0, 8'h00, 7'h00, 7'h00},  // soft reset
    '{1'b0, 8'h45, 32'h0000_0011, 1'b0, 8'h00, 7'h00, 7'h00},  // data, no status
    '{1'b0, 8'h90, 32'h0000_0001, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'h00, 32'h0000_0002, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'h7F, 32'hFFFF_FFFF, 1'b1, 8'h90, 7'h00, 7'h7F},
    '{1'b0, 8'h7F, 32'h0000_0003, 1'b0, 8'h00, 7'h00, 7'h00},  // running status
    '{1'b0, 8'h00, 32'h0000_0000, 1'b1, 8'h80, 7'h7F, 7'h00},  // velocity zero
    '{1'b0, 8'hBF, 32'h0000_0004, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'h07, 32'h0000_0005, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'hF8, 32'h0000_0006, 1'b0, 8'h00, 7'h00, 7'h00},  // clock mid-message
    '{1'b0, 8'h00, 32'h0000_0007, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'h79, 32'h0000_0008, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'h00, 32'h0000_0009, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'hC3, 32'h0000_000A, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'h7F, 32'h0000_000B, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'hE3, 32'h0000_000C, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'h7F, 32'h0000_000D, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'h7F, 32'h0000_000E, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'hF0, 32'h0000_000F, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'h12, 32'h0000_0010, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'hF7, 32'h0000_0011, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'h10, 32'h0000_0012, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'hF2, 32'h0000_0013, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'h01, 32'h0000_0014, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'h02, 32'h0000_0015, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'hF4, 32'h0000_0016, 1'b0, 8'h00, 7'h00, 7'h00},
    '{1'b0, 8'h33, 32'h0000_0017, 1'b0, 8'h00, 7'h00, 7'h00}
  };

  localparam int RANDOM_ITEMS = 1520;
  localparam int HOLD_CYCLES  = 400;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;   // stream_byte[7:0], frame_stamp[39:8]
  logic [0:0]   in_tuser = '0;   // mode[0]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // status, first, second, time_tag, bend, program, bank, volume,
  // expression, pan, sustain, pressure, zero fill
  logic [119:0] out_tdata;

  midi_stream_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Parser model state.
  msp_pkg::chan_t chans [msp_pkg::CHANNEL_COUNT];
  bit [7:0]   run_status;
  bit [7:0]   cur_status;
  bit [6:0]   held [2];
  bit [1:0]   got_count;
  bit [1:0]   want_count;
  bit [1:0]   skip_left;
  bit         sysex_on;

  feed_t      feed_q [$];
  midi_word_t pending_words [$];
  int         fail_count = 0;
  int         n_counted = 0;
  bit         hold_req = 1'b0;

  function automatic bit [1:0] data_len(bit [7:0] st);
    if (!st[7] || st >= msp_pkg::SYSTEM_FIRST) return 2'd0;
    if (st[7:4] == msp_pkg::MSG_PROGRAM || st[7:4] == msp_pkg::MSG_PRESSURE) return 2'd1;
    return 2'd2;
  endfunction

  task automatic restore_defaults();
    for (int i = 0; i < msp_pkg::CHANNEL_COUNT; i++) chans[i] = msp_pkg::CHAN_DEFAULT;
    run_status = '0;
    cur_status = '0;
    held[0] = '0;
    held[1] = '0;
    got_count = '0;
    want_count = '0;
    skip_left = '0;
    sysex_on = 1'b0;
  endtask

  task automatic parse_byte(input bit mode, input bit [7:0] b, input bit [31:0] stamp,
                            output bit emitted, output midi_word_t w);
    bit [3:0] ch;
    bit [7:0] st;
    bit [6:0] d1;
    bit [6:0] d2;
    msp_pkg::chan_t c;
    emitted = 1'b0;
    w = '0;
    if (mode) begin
      restore_defaults();
      return;
    end
    if (b >= msp_pkg::REALTIME_FIRST) return;
    if (b[7]) begin
      if (b >= msp_pkg::SYSTEM_FIRST) begin
        run_status = '0;
        cur_status = '0;
        got_count = '0;
        want_count = '0;
        skip_left = '0;
        if (b == msp_pkg::SYSEX_START) begin
          sysex_on = 1'b1;
        end else begin
          sysex_on = 1'b0;
          if (b == msp_pkg::MTC_QUARTER || b == msp_pkg::SONG_SELECT) skip_left = 2'd1;
          else if (b == msp_pkg::SONG_POSITION) skip_left = 2'd2;
        end
      end else begin
        sysex_on = 1'b0;
        skip_left = '0;
        run_status = b;
        cur_status = b;
        got_count = '0;
        want_count = data_len(b);
      end
      return;
    end
    if (sysex_on) return;
    if (skip_left != 0) begin
      skip_left--;
      return;
    end
    if (cur_status == 0) begin
      if (run_status == 0) return;
      cur_status = run_status;
      want_count = data_len(cur_status);
      got_count = '0;
    end
    if (want_count == 0) return;
    if (got_count < 2) held[got_count[0]] = b[6:0];
    got_count = got_count + 2'd1;
    if (got_count < want_count) return;

    st = cur_status;
    ch = st[3:0];
    d1 = held[0];
    d2 = (want_count > 1) ? held[1] : 7'd0;
    if (int'(ch) < msp_pkg::CHANNEL_COUNT) begin
      c = chans[ch];
      if (st[7:4] == msp_pkg::MSG_NOTE_ON && d2 == 0) st = {msp_pkg::MSG_NOTE_OFF, ch};
      case (st[7:4])
        msp_pkg::MSG_CONTROL: begin
          case (d1)
            msp_pkg::CC_BANK_HI:    c.bank_hi = d2;
            msp_pkg::CC_BANK_LO:    c.bank_lo = d2;
            msp_pkg::CC_VOLUME:     c.volume = d2;
            msp_pkg::CC_PAN:        c.pan = d2;
            msp_pkg::CC_EXPRESSION: c.expression = d2;
            msp_pkg::CC_SUSTAIN:    c.sustain = (d2 >= 7'd64);
            msp_pkg::CC_RESET_ALL: begin
              c.bend = msp_pkg::BEND_CENTER;
              c.expression = msp_pkg::LEVEL_MAX;
              c.pan = msp_pkg::PAN_CENTER;
              c.sustain = 1'b0;
              c.pressure = '0;
            end
            default: ;
          endcase
        end
        msp_pkg::MSG_PROGRAM:    c.prog_num = d1;
        msp_pkg::MSG_PRESSURE:   c.pressure = d1;
        msp_pkg::MSG_PITCH_BEND: c.bend = {d2, d1};
        default: ;
      endcase
      chans[ch] = c;
      emitted = 1'b1;
      w.status = st;
      w.first = d1;
      w.second = d2;
      w.time_tag = stamp;
      w.bend = c.bend;
      w.prog = c.prog_num;
      w.bank = {c.bank_hi, c.bank_lo};
      w.volume = c.volume;
      w.expression = c.expression;
      w.pan = c.pan;
      w.sustain = c.sustain;
      w.pressure = c.pressure;
    end
    cur_status = run_status;
    want_count = data_len(run_status);
    got_count = '0;
    held[0] = '0;
    held[1] = '0;
  endtask

  function automatic bit [31:0] pick_stamp();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic bit [7:0] pick_data();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'h7F;
    return 8'($urandom_range(0, 127));
  endfunction

  task automatic push_feed(bit mode, bit [7:0] b, bit counts);
    feed_t f;
    f.mode = mode;
    f.b = b;
    f.stamp = pick_stamp();
    f.fixed_valid = 1'b0;
    f.fixed = '0;
    feed_q.push_back(f);
    if (counts) n_counted++;
  endtask

  // Data byte of a message, now and then preceded by a real-time byte.
  task automatic push_msg_byte(bit [7:0] b);
    if ($urandom_range(0, 19) == 0) push_feed(1'b0, 8'($urandom_range(248, 255)), 1'b0);
    push_feed(1'b0, b, 1'b1);
  endtask

  task automatic build_random_feed();
    int       kind;
    int       r;
    bit       gen_run;
    bit [7:0] gen_st;
    bit [3:0] mt;
    bit [7:0] d1;
    bit [7:0] d2;
    bit [7:0] sc;
    bit [1:0] n;
    gen_run = 1'b0;
    gen_st = '0;
    while (n_counted < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 62 || (kind >= 95 && kind < 98)) begin
        if (!(gen_run && $urandom_range(0, 2) != 0) || kind >= 95) begin
          mt = 4'($urandom_range(8, 14));
          gen_st = {mt, 4'($urandom_range(0, 15))};
          gen_run = 1'b1;
          push_feed(1'b0, gen_st, 1'b1);
        end
        n = data_len(gen_st);
        d1 = pick_data();
        d2 = pick_data();
        if (gen_st[7:4] == msp_pkg::MSG_CONTROL) begin
          r = $urandom_range(0, 13);
          case (r)
            0: d1 = {1'b0, msp_pkg::CC_BANK_HI};
            1: d1 = {1'b0, msp_pkg::CC_VOLUME};
            2: d1 = {1'b0, msp_pkg::CC_PAN};
            3: d1 = {1'b0, msp_pkg::CC_EXPRESSION};
            4: d1 = {1'b0, msp_pkg::CC_BANK_LO};
            5: d1 = {1'b0, msp_pkg::CC_SUSTAIN};
            6: d1 = {1'b0, msp_pkg::CC_RESET_ALL};
            default: ;
          endcase
        end
        if (gen_st[7:4] == msp_pkg::MSG_NOTE_ON && $urandom_range(0, 3) == 0) d2 = 8'h00;
        // A truncated message drops its last data byte.
        if (kind >= 95) n = n - 2'd1;
        if (n >= 1) push_msg_byte(d1);
        if (n >= 2) push_msg_byte(d2);
      end else if (kind < 68) begin
        push_feed(1'b0, 8'($urandom_range(248, 255)), 1'b0);
      end else if (kind < 76) begin
        push_feed(1'b0, msp_pkg::SYSEX_START, 1'b1);
        repeat ($urandom_range(0, 5)) push_feed(1'b0, pick_data(), 1'b1);
        if ($urandom_range(0, 3) != 0) push_feed(1'b0, msp_pkg::SYSEX_END, 1'b1);
        gen_run = 1'b0;
      end else if (kind < 86) begin
        sc = 8'($urandom_range(241, 246));
        push_feed(1'b0, sc, 1'b1);
        if (sc == msp_pkg::MTC_QUARTER || sc == msp_pkg::SONG_SELECT) begin
          push_msg_byte(pick_data());
        end else if (sc == msp_pkg::SONG_POSITION) begin
          push_msg_byte(pick_data());
          push_msg_byte(pick_data());
        end
        gen_run = 1'b0;
      end else if (kind < 95) begin
        d1 = 8'($urandom_range(0, 255));
        push_feed(1'b0, d1, d1 < msp_pkg::REALTIME_FIRST);
        if (d1[7]) gen_run = 1'b0;
      end else begin
        push_feed(1'b1, 8'($urandom_range(0, 255)), 1'b1);
        gen_run = 1'b0;
      end
    end
  endtask

  function automatic string show_word(midi_word_t w);
    return {$sformatf("st=%02h d1=%02h d2=%02h tag=%08h bend=%04h prg=%02h bank=%04h",
                      w.status, w.first, w.second, w.time_tag, w.bend, w.prog, w.bank),
            $sformatf(" vol=%02h expr=%02h pan=%02h sus=%0d prs=%02h pad=%0d",
                      w.volume, w.expression, w.pan, w.sustain, w.pressure, w.pad)};
  endfunction

  task automatic check_word(midi_word_t got);
    midi_word_t want;
    if (pending_words.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result word: %s", show_word(got));
      return;
    end
    want = pending_words.pop_front();
    if (got.status !== want.status || got.first !== want.first ||
        got.second !== want.second || got.time_tag !== want.time_tag ||
        got.bend !== want.bend || got.prog !== want.prog ||
        got.bank !== want.bank || got.volume !== want.volume ||
        got.expression !== want.expression || got.pan !== want.pan ||
        got.sustain !== want.sustain || got.pressure !== want.pressure ||
        got.pad !== want.pad) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch: expected %s", show_word(want));
        $display("          actual   %s", show_word(got));
      end
    end
  endtask

  // Output side: random stalls, quiet stretches, and one long hold-off.
  task automatic drain_words();
    int stall;
    int w_cnt;
    w_cnt = 0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = (((w_cnt / 40) % 4) == 1) ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      check_word(midi_word_t'(out_tdata));
      w_cnt++;
    end
  endtask

  initial begin
    feed_t      f;
    midi_word_t w;
    bit         emitted;
    int         gap;
    int         hold_at;
    int         pause_at;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      f.mode = DIRECTED[i].mode;
      f.b = DIRECTED[i].b;
      f.stamp = DIRECTED[i].stamp;
      f.fixed_valid = DIRECTED[i].typed;
      f.fixed = '0;
      if (DIRECTED[i].typed) begin
        f.fixed.status = DIRECTED[i].t_st;
        f.fixed.first = DIRECTED[i].t_d1;
        f.fixed.second = DIRECTED[i].t_d2;
        f.fixed.time_tag = DIRECTED[i].stamp;
        f.fixed.bend = msp_pkg::BEND_CENTER;
        f.fixed.volume = msp_pkg::LEVEL_MAX;
        f.fixed.expression = msp_pkg::LEVEL_MAX;
        f.fixed.pan = msp_pkg::PAN_CENTER;
      end
      feed_q.push_back(f);
    end
    build_random_feed();
    hold_at = DIRECTED_ROWS + 300;
    pause_at = DIRECTED_ROWS + 900;

    restore_defaults();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    fork
      drain_words();
    join_none

    for (int i = 0; i < feed_q.size(); i++) begin
      f = feed_q[i];
      if (i == hold_at) hold_req = 1'b1;
      if (i >= hold_at && i < hold_at + 200) gap = 0;
      else if (((i / 150) % 4) == 2) gap = 0;
      else gap = $urandom_range(0, 16);
      // The pause always has a nonzero gap so in_tvalid drops cleanly.
      if (i == pause_at && gap == 0) gap = 1;
      if (i == pause_at || gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        if (i == pause_at) begin
          while (pending_words.size() != 0) @(posedge clk);
        end
      end
      in_tvalid <= 1'b1;
      in_tuser <= f.mode;
      in_tdata <= {f.stamp, f.b};
      do @(posedge clk); while (!in_tready);
      parse_byte(f.mode, f.b, f.stamp, emitted, w);
      if (emitted) pending_words.push_back(f.fixed_valid ? f.fixed : w);
    end
    in_tvalid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/msp_pkg.sv
hw/rtl/midi_stream_parser.sv
sim/testbench.sv
